@@ rtl/core/ssdbm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssdbm_pkg: shared constants of the SSD block-matching disparity block
// Default sizes, register indexes and the starting cost of the search.
// ----------------------------------------------------------------------------
package ssdbm_pkg;

  localparam int WINDOW_SIZE_DEF     = 9;
  localparam int DISPARITY_COUNT_DEF = 30;
  localparam int MAX_WIDTH_DEF       = 1024;

  localparam int CFG_W  = 11;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  localparam int          COST_W     = 32;
  localparam logic [31:0] COST_START = 32'd10000000;

endpackage

@@ rtl/core/ssdbm_ram.sv @@
// ----------------------------------------------------------------------------
// ssdbm_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ssdbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ssd_block_matching_disparity.sv @@
// ----------------------------------------------------------------------------
// ssd_block_matching_disparity: SSD block-matching stereo disparity
// Keeps the last lines of both images and, for each centre pixel in the valid
// region, searches the shift with the lowest windowed sum of squared
// differences using one shared square-and-accumulate unit.
// ----------------------------------------------------------------------------
//  channel   dir  group              contents
//  s_axis    in   s_tvalid/tready    tdata: left_pixel, right_pixel
//  m_axis    out  m_tvalid/tready    tdata: out_row, out_column, best_shift,
//                                    scaled_disparity
//  cfg       in   cfg_we             cfg_index, cfg_data (no read-back)
//
// An item outside the valid region leaves the block ready for the next one. For
// an item that completes a centre, the line store read port delivers one pixel
// pair per cycle to the shared unit.
// The result waits in an output register; a finished search waits until that
// register is free, and input is taken again once the result has moved in.
// Reset clears the raster position, the size registers and the sequencer
// state; the line stores are not cleared.
module ssd_block_matching_disparity #(
  parameter int WINDOW_SIZE     = ssdbm_pkg::WINDOW_SIZE_DEF,
  parameter int DISPARITY_COUNT = ssdbm_pkg::DISPARITY_COUNT_DEF,
  parameter int MAX_WIDTH       = ssdbm_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // left_pixel, right_pixel
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [39:0]                  m_tdata,   // out_row, out_column,
                                                  // best_shift, scaled_disparity
  input  logic                         cfg_we,
  input  logic [ssdbm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ssdbm_pkg::CFG_W-1:0]  cfg_data
);

  localparam int HALF   = WINDOW_SIZE / 2;
  localparam int SOFF   = WINDOW_SIZE - 2 * HALF;
  localparam int DEPTH  = WINDOW_SIZE * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(WINDOW_SIZE);
  localparam int CI     = $clog2(MAX_WIDTH);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = ssdbm_pkg::CFG_W;
  localparam int DW     = $clog2(DISPARITY_COUNT);
  localparam int XW     = $clog2(WINDOW_SIZE);
  localparam int CW     = ssdbm_pkg::COST_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                 st;
  logic [RW-1:0]              image_width;
  logic [RW-1:0]              image_height;
  logic [CI-1:0]              col;
  logic [RW-1:0]              row;
  logic [SW-1:0]              slot;
  logic [CI-1:0]              base_col;
  logic [RW-1:0]              cen_row;
  logic [SW-1:0]              slot0;
  logic [DW-1:0]              dc;
  logic [XW-1:0]              yc;
  logic [XW-1:0]              xc;
  logic [SW-1:0]              rslot;
  logic                       v1, l1, f1, v2, l2, f2;
  logic [DW-1:0]              d1, d2;
  logic [15:0]                sq;
  logic [CW-1:0]              acc;
  logic [CW-1:0]              best_cost;
  logic [DW-1:0]              best;
  logic [7:0]                 lpix, rpix;
  logic [7:0]                 scale_tab [DISPARITY_COUNT];
  logic [9:0]                 o_row, o_col;
  logic [5:0]                 o_best;
  logic [7:0]                 o_scale;

  logic [EW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic          take;
  logic          qualify;
  logic [AW-1:0] waddr, laddr, raddr;
  logic [RW:0]   col_inc;
  logic [RW-1:0] row_inc;
  logic [CW-1:0] sum;
  logic          run_last;

  // Scaled disparity table, fixed at elaboration.
  for (genvar gi = 0; gi < DISPARITY_COUNT; gi++) begin : g_scale
    assign scale_tab[gi] = 8'((gi * 255) / DISPARITY_COUNT);
  end

  // Effective frame size.
  always_comb begin
    if (image_width == '0) begin
      eff_w = EW'(1);
    end else if ({1'b0, image_width} > (RW+1)'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    eff_h = (image_height == '0) ? RW'(1) : image_height;
  end

  assign s_tready = (st == ST_IDLE);
  assign take     = s_tvalid && s_tready;
  assign col_inc  = (RW+1)'(col) + (RW+1)'(1);
  assign row_inc  = row + RW'(1);

  assign qualify = (row >= RW'(2 * HALF + 1)) && (row < eff_h) &&
                   ((RW+1)'(col) >= (RW+1)'(2 * HALF + DISPARITY_COUNT)) &&
                   ((RW+1)'(col) + (RW+1)'(3) <= (RW+1)'(eff_w));

  // Store addresses: line slot times line length plus column.
  assign waddr = AW'(slot * MAX_WIDTH) + AW'(col);
  assign laddr = AW'(rslot * MAX_WIDTH) + AW'(base_col) + AW'(xc);
  assign raddr = laddr + AW'(dc);

  assign slot0 = (SW'(SOFF) + slot >= SW'(WINDOW_SIZE)) ?
                 SW'(SOFF) + slot - SW'(WINDOW_SIZE) : SW'(SOFF) + slot;

  ssdbm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_left (
    .clk(clk), .we(take), .waddr(waddr), .wdata(s_tdata[7:0]),
    .raddr(laddr), .rdata(lpix)
  );

  ssdbm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_right (
    .clk(clk), .we(take), .waddr(waddr), .wdata(s_tdata[15:8]),
    .raddr(raddr), .rdata(rpix)
  );

  assign run_last = (dc == DW'(DISPARITY_COUNT - 1)) &&
                    (yc == XW'(WINDOW_SIZE - 1)) && (xc == XW'(WINDOW_SIZE - 1));
  assign sum = acc + CW'(sq);

  // Configuration registers and raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ssdbm_pkg::WIDTH_RESET;
      image_height <= ssdbm_pkg::HEIGHT_RESET;
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (cfg_we && (cfg_index == ssdbm_pkg::REG_WIDTH ||
                            cfg_index == ssdbm_pkg::REG_HEIGHT)) begin
      if (cfg_index == ssdbm_pkg::REG_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (take) begin
      if (col_inc >= (RW+1)'(eff_w)) begin
        col <= '0;
        if (row_inc >= eff_h) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row_inc;
          slot <= (slot == SW'(WINDOW_SIZE - 1)) ? '0 : slot + SW'(1);
        end
      end else begin
        col <= CI'(col_inc);
      end
    end
  end

  // Sequencer over shift, window row and window column.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      v1 <= 1'b0;
      v2 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v1 <= (st == ST_RUN);
      v2 <= v1;
      // The output register is filled by a finished search or emptied by a transfer.
      if (st == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (take && qualify) begin
            st <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (run_last) begin
            st <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (v2 && f2) begin
            st <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Counters, pipeline payload and the shared square-accumulate unit.
  always_ff @(posedge clk) begin
    l1 <= (yc == XW'(WINDOW_SIZE - 1)) && (xc == XW'(WINDOW_SIZE - 1));
    f1 <= run_last;
    d1 <= dc;
    l2 <= l1;
    f2 <= f1;
    d2 <= d1;
    sq <= 16'($signed({1'b0, lpix}) - $signed({1'b0, rpix})) *
          16'($signed({1'b0, lpix}) - $signed({1'b0, rpix}));
    if (take) begin
      base_col  <= CI'(col - CI'(2 * HALF + DISPARITY_COUNT - 1));
      cen_row   <= row - RW'(HALF);
      dc        <= '0;
      yc        <= '0;
      xc        <= '0;
      rslot     <= slot0;
      acc       <= '0;
      best_cost <= ssdbm_pkg::COST_START;
      best      <= '0;
    end else if (st == ST_RUN) begin
      if (xc == XW'(WINDOW_SIZE - 1)) begin
        xc <= '0;
        if (yc == XW'(WINDOW_SIZE - 1)) begin
          yc    <= '0;
          dc    <= dc + DW'(1);
          rslot <= slot0;
        end else begin
          yc    <= yc + XW'(1);
          rslot <= (rslot == SW'(WINDOW_SIZE - 1)) ? '0 : rslot + SW'(1);
        end
      end else begin
        xc <= xc + XW'(1);
      end
    end
    if (v2) begin
      if (l2) begin
        acc <= '0;
        if (sum < best_cost) begin
          best_cost <= sum;
          best      <= d2;
        end
      end else begin
        acc <= sum;
      end
    end
    if (st == ST_DONE && (!m_tvalid || m_tready)) begin
      o_row   <= cen_row[9:0];
      o_col   <= 10'(base_col) + 10'(HALF);
      o_best  <= 6'(best);
      o_scale <= scale_tab[best];
    end
  end

  assign m_tdata = {6'd0, o_scale, o_best, o_col, o_row};

  // Checks on the sequencer.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (st != ST_IDLE) |-> !s_tready) else $error("input taken while busy");
  a_final_in_drain: assert property (@(posedge clk) disable iff (rst)
    (v2 && f2) |-> (st == ST_DRAIN)) else $error("search ended out of step");
  a_cost_bound: assert property (@(posedge clk) disable iff (rst)
    (st != ST_IDLE) |-> (best_cost <= ssdbm_pkg::COST_START))
    else $error("best cost above start");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(st == ST_DONE)) else $error("result without search");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the SSD block-matching disparity block
// Streams stereo pixel pairs frame by frame through several image sizes,
// predicts every disparity result with a behavioural window-cost search and
// compares each output transfer field by field, with random idling on both
// sides of the stream.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WIN    = ssdbm_pkg::WINDOW_SIZE_DEF;
  localparam int SHIFTS = ssdbm_pkg::DISPARITY_COUNT_DEF;
  localparam int MAXW   = ssdbm_pkg::MAX_WIDTH_DEF;
  localparam int HALF   = WIN / 2;
  localparam int DEPTH  = WIN * MAXW;
  localparam int IW     = ssdbm_pkg::CFG_IW;
  localparam int STALL_LIMIT = 20000;

  // Register indexes beyond the register list.
  localparam logic [IW-1:0] REG_BEYOND_LO = IW'(2);
  localparam logic [IW-1:0] REG_BEYOND_HI = IW'(3);

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] column;
    logic [5:0] shift;
    logic [7:0] scaled;
  } disparity_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [15:0]                   s_tdata;   // left_pixel, right_pixel
  logic                          m_tvalid;
  logic                          m_tready;
  logic [39:0]                   m_tdata;   // out_row, out_column, best_shift, scaled_disparity
  logic                          cfg_we;
  logic [IW-1:0]                 cfg_index;
  logic [ssdbm_pkg::CFG_W-1:0]   cfg_data;

  // Stimulus and expectations.
  logic [15:0]  pixel_q[$];
  disparity_t   disparity_q[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           in_taken;
  int           error_count;
  int           quiet_cycles;

  // Predictor state.
  logic [7:0]   left_lines[DEPTH];
  logic [7:0]   right_lines[DEPTH];
  int           pos_col;
  int           pos_row;
  logic [10:0]  width_reg;
  logic [10:0]  height_reg;

  ssd_block_matching_disparity dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Append one pixel pair to the end of the stimulus queue.
  task automatic queue_pixel(input logic [15:0] pair);
    pixel_q.insert(pixel_q.size(), pair);
  endtask

  function automatic int line_index(input int row, input int col);
    return ((row % WIN) * MAXW + col) % DEPTH;
  endfunction

  // Windowed sum of squared differences for one centre and one shift.
  function automatic int window_ssd(input int cr, input int cc, input int d);
    int sum;
    int diff;
    sum = 0;
    for (int y = -HALF; y <= HALF; y++) begin
      for (int x = -HALF; x <= HALF; x++) begin
        diff = int'(left_lines[line_index(cr + y, cc + x)])
             - int'(right_lines[line_index(cr + y, cc + x + d)]);
        sum += diff * diff;
      end
    end
    return sum;
  endfunction

  // Store one pixel pair, search the completed centre if any, advance raster.
  task automatic predict_disparity(input logic [15:0] pair);
    int w;
    int h;
    int cr;
    int cc;
    int best_cost;
    int best;
    int cost;
    disparity_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    if (pos_col < MAXW) begin
      left_lines[line_index(pos_row, pos_col)]  = pair[7:0];
      right_lines[line_index(pos_row, pos_col)] = pair[15:8];
    end
    if (pos_row >= 2 * HALF + 1 && pos_row < h && pos_col >= 2 * HALF + SHIFTS &&
        pos_col + 3 <= w) begin
      cr = pos_row - HALF;
      cc = pos_col - HALF - (SHIFTS - 1);
      best_cost = int'(ssdbm_pkg::COST_START);
      best = 0;
      for (int d = 0; d < SHIFTS; d++) begin
        cost = window_ssd(cr, cc, d);
        if (cost < best_cost) begin
          best_cost = cost;
          best = d;
        end
      end
      res.row    = cr[9:0];
      res.column = cc[9:0];
      res.shift  = best[5:0];
      res.scaled = 8'((best * 255) / SHIFTS);
      disparity_q.insert(disparity_q.size(), res);
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // Input side: note each accepted transfer and predict its result.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      in_taken = 1'b1;
      predict_disparity(s_tdata);
    end
  end

  // Sender: holds an item until taken, otherwise offers the next or idles.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      s_tvalid <= 1'b1;
    end else if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      s_tdata  <= pixel_q.pop_front();
      s_tvalid <= 1'b1;
    end else begin
      s_tvalid <= 1'b0;
    end
    in_taken = 1'b0;
  end

  // Receiver readiness.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Output side: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    disparity_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (disparity_q.size() == 0) begin
        report_mismatch("unexpected result, row", int'(m_tdata[9:0]), -1);
      end else begin
        want = disparity_q.pop_front();
        if (m_tdata[9:0] != want.row)
          report_mismatch("out_row", int'(m_tdata[9:0]), int'(want.row));
        if (m_tdata[19:10] != want.column)
          report_mismatch("out_column", int'(m_tdata[19:10]), int'(want.column));
        if (m_tdata[25:20] != want.shift)
          report_mismatch("best_shift", int'(m_tdata[25:20]), int'(want.shift));
        if (m_tdata[33:26] != want.scaled)
          report_mismatch("scaled_disparity", int'(m_tdata[33:26]), int'(want.scaled));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every item is taken and every result has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_q.size() != 0 || s_tvalid || disparity_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(input logic [IW-1:0] idx,
                                input logic [ssdbm_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ssdbm_pkg::REG_WIDTH) width_reg = val;
    else if (idx == ssdbm_pkg::REG_HEIGHT) height_reg = val;
    if (idx == ssdbm_pkg::REG_WIDTH || idx == ssdbm_pkg::REG_HEIGHT) begin
      pos_col = 0;
      pos_row = 0;
    end
  endtask

  // Queue rows whose right image is the left one shifted by a random
  // disparity, with occasional noise and some fully random rows.
  task automatic queue_rows(input int w, input int rows);
    logic [7:0] left_row[MAXW];
    int d;
    bit noisy;
    logic [7:0] r;
    for (int y = 0; y < rows; y++) begin
      d = $urandom_range(SHIFTS - 1);
      noisy = ($urandom_range(7) == 0);
      for (int x = 0; x < w; x++) left_row[x] = 8'($urandom_range(255));
      for (int x = 0; x < w; x++) begin
        if (noisy || x < d || $urandom_range(15) == 0) r = 8'($urandom_range(255));
        else r = left_row[x - d];
        queue_pixel({r, left_row[x]});
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    quiet_cycles = 0;
    in_taken = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 78;
    pos_col = 0;
    pos_row = 0;
    width_reg = ssdbm_pkg::WIDTH_RESET;
    height_reg = ssdbm_pkg::HEIGHT_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      left_lines[i] = '0;
      right_lines[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pixel extremes at the reset size.
    queue_pixel(16'h0000);
    queue_pixel(16'hFFFF);
    queue_pixel(16'h00FF);
    queue_pixel(16'hFF00);
    queue_pixel(16'h55AA);
    queue_pixel(16'hAA55);
    wait_drained();
    // Indexes beyond the register list must be ignored.
    write_register(REG_BEYOND_LO, 11'h7FF);
    write_register(REG_BEYOND_HI, 11'h000);
    queue_pixel(16'h0180);
    queue_pixel(16'h8001);
    wait_drained();
    // Zero width and height act as one.
    write_register(ssdbm_pkg::REG_WIDTH, 11'd0);
    write_register(ssdbm_pkg::REG_HEIGHT, 11'd0);
    for (int i = 0; i < 4; i++) queue_pixel(16'($urandom));
    wait_drained();
    // Oversized width saturates; largest height.
    write_register(ssdbm_pkg::REG_WIDTH, 11'h7FF);
    write_register(ssdbm_pkg::REG_HEIGHT, 11'h7FF);
    for (int i = 0; i < 4; i++) queue_pixel(16'($urandom));
    wait_drained();

    // Small frame: ten flat rows first so every shift ties, then random rows.
    write_register(ssdbm_pkg::REG_WIDTH, 11'd48);
    write_register(ssdbm_pkg::REG_HEIGHT, 11'd12);
    for (int i = 0; i < 48 * 10; i++) queue_pixel(16'h3C3C);
    wait_drained();                 // sender pauses until all results are in
    queue_rows(48, 2);
    wait_drained();

    // Swap the idling of the two sides.
    send_idle_pct = 78;
    recv_idle_pct = 6;
    write_register(ssdbm_pkg::REG_WIDTH, 11'd56);
    write_register(ssdbm_pkg::REG_HEIGHT, 11'd13);
    queue_rows(56, 10);
    wait_drained();

    // No idling at all while the same frame is finished.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_rows(56, 3);
    wait_drained();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
